@@ hw/rtl/bcslc_pkg.sv @@
// Package for the BCD clock street light controller: register indexes, reset values, BCD helpers.
package bcslc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TICKS_PER_SECOND  = 2'd0,
        CFG_EVENING_HOUR      = 2'd1,
        CFG_MORNING_HOUR      = 2'd2,
        CFG_TRAFFIC_THRESHOLD = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Reset values of the configuration registers.
    localparam logic [5:0] RST_TICKS_PER_SECOND  = 6'd20;
    localparam logic [5:0] RST_EVENING_HOUR      = 6'h18;
    localparam logic [5:0] RST_MORNING_HOUR      = 6'h05;
    localparam logic [7:0] RST_TRAFFIC_THRESHOLD = 8'd15;

    // Input action codes.
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Rollover points in packed BCD.
    localparam logic [7:0] BCD_SIXTY      = 8'h60;
    localparam logic [7:0] BCD_TWENTYFOUR = 8'h24;

    // Two-digit packed BCD increment; the tens digit wraps within four bits.
    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = v[3:0];
        hi = v[7:4];
        if (lo >= 4'd9) begin
            lo = 4'd0;
            hi = hi + 4'd1;
        end else begin
            lo = lo + 4'd1;
        end
        return {hi, lo};
    endfunction

endpackage

@@ hw/rtl/bcd_clock_street_light_control.sv @@
// Top level of the BCD clock street light controller.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_action, i_sample
//  out     | output    | o_out_valid / i_out_stall  | o_hours_bcd, o_minutes_bcd,
//          |           |                            | o_seconds_bcd, o_lights_on,
//          |           |                            | o_high_voltage
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A beat is accepted into the input register, and the update pass then loads its result
// into the result register. One beat can be taken every cycle while the output does not
// stall; the rate is set by the single update pass between the input register and the result register.
// Reset is synchronous and active low; it restores the configuration defaults, clears
// the clock and prescaler, and sets both light latches high.
// A stalled output holds its beat; the input register then holds its beat too and the
// input stalls only when both are occupied.
module bcd_clock_street_light_control
    import bcslc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [7:0]            i_sample,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [5:0]            o_hours_bcd,
    output logic [6:0]            o_minutes_bcd,
    output logic [6:0]            o_seconds_bcd,
    output logic                  o_lights_on,
    output logic                  o_high_voltage,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [5:0] r_ticks_per_second;
    logic [5:0] r_evening_hour;
    logic [5:0] r_morning_hour;
    logic [7:0] r_traffic_threshold;

    // Clock state. The clock digits stay valid BCD and the tick count is binary, so the narrow widths hold it all.
    logic [5:0] r_tick_count, n_tick_count;
    logic [6:0] r_sec, n_sec;
    logic [6:0] r_min, n_min;
    logic [5:0] r_hour, n_hour;
    logic       r_lights, n_lights;
    logic       r_voltage, n_voltage;

    // Input register.
    logic       r_in_valid;
    logic       r_action;
    logic [7:0] r_sample;

    // Result register.
    logic       r_out_valid;
    logic [5:0] r_out_hours;
    logic [6:0] r_out_minutes;
    logic [6:0] r_out_seconds;
    logic       r_out_lights;
    logic       r_out_voltage;

    logic out_free;
    logic advance;
    logic in_take;

    // The result register can be loaded when empty or when its beat leaves now.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second  <= RST_TICKS_PER_SECOND;
            r_evening_hour      <= RST_EVENING_HOUR;
            r_morning_hour      <= RST_MORNING_HOUR;
            r_traffic_threshold <= RST_TRAFFIC_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TICKS_PER_SECOND:  r_ticks_per_second  <= i_cfg_data[5:0];
                CFG_EVENING_HOUR:      r_evening_hour      <= i_cfg_data[5:0];
                CFG_MORNING_HOUR:      r_morning_hour      <= i_cfg_data[5:0];
                CFG_TRAFFIC_THRESHOLD: r_traffic_threshold <= i_cfg_data;
            endcase
        end
    end

    // Update pass for the beat in the input register.
    always_comb begin
        logic [6:0] limit;
        logic [6:0] count_inc;
        logic [7:0] sec_inc;
        logic [7:0] min_inc;
        logic [7:0] hour_inc;
        logic [5:0] hour_next;

        n_tick_count = r_tick_count;
        n_sec        = r_sec;
        n_min        = r_min;
        n_hour       = r_hour;
        n_lights     = r_lights;
        n_voltage    = r_voltage;

        // A zero setting behaves as one tick per second.
        limit     = (r_ticks_per_second == 6'd0) ? 7'd1 : {1'b0, r_ticks_per_second};
        count_inc = {1'b0, r_tick_count} + 7'd1;
        sec_inc   = bcd_inc({1'b0, r_sec});
        min_inc   = bcd_inc({1'b0, r_min});
        hour_inc  = bcd_inc({2'b00, r_hour});
        hour_next = (hour_inc >= BCD_TWENTYFOUR) ? 6'd0 : hour_inc[5:0];

        if (r_action == ACT_TICK) begin
            if (count_inc >= limit) begin
                n_tick_count = 6'd0;
                if (sec_inc < BCD_SIXTY) begin
                    n_sec = sec_inc[6:0];
                end else begin
                    n_sec = 7'd0;
                    if (min_inc < BCD_SIXTY) begin
                        n_min = min_inc[6:0];
                    end else begin
                        // Hour change: the night window is at or after evening, or
                        // before morning.
                        n_min    = 7'd0;
                        n_hour   = hour_next;
                        n_lights = (hour_next >= r_evening_hour) ||
                                   (hour_next < r_morning_hour);
                    end
                end
            end else begin
                n_tick_count = count_inc[5:0];
            end
        end else if (r_lights) begin
            // With the lights off the voltage latch keeps its value.
            n_voltage = (r_sample > r_traffic_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= 6'd0;
            r_sec        <= 7'd0;
            r_min        <= 7'd0;
            r_hour       <= 6'd0;
            r_lights     <= 1'b1;
            r_voltage    <= 1'b1;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_tick_count <= n_tick_count;
                r_sec        <= n_sec;
                r_min        <= n_min;
                r_hour       <= n_hour;
                r_lights     <= n_lights;
                r_voltage    <= n_voltage;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= i_action;
            r_sample <= i_sample;
        end
        if (advance) begin
            r_out_hours   <= n_hour;
            r_out_minutes <= n_min;
            r_out_seconds <= n_sec;
            r_out_lights  <= n_lights;
            r_out_voltage <= n_voltage;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hours_bcd    = r_out_hours;
    assign o_minutes_bcd  = r_out_minutes;
    assign o_seconds_bcd  = r_out_seconds;
    assign o_lights_on    = r_out_lights;
    assign o_high_voltage = r_out_voltage;

endmodule

@@ tb/tb_bcd_clock_street_light_control.sv @@
// Self-checking testbench for the BCD clock street light controller.
`timescale 1ns / 1ps

module tb_bcd_clock_street_light_control;
    import bcslc_pkg::*;

    // One observed reading of the controller: the clock and both light latches.
    typedef struct packed {
        logic [5:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic       lights;
        logic       volts;
    } t_clock_reading;

    // Tracks the clock and the light latches beat by beat and holds the readings
    // still owed by the block, oldest first.
    class clock_light_tracker;
        logic [5:0]     tick_limit;
        logic [5:0]     dusk_hour;
        logic [5:0]     dawn_hour;
        logic [7:0]     busy_level;
        logic [5:0]     prescale;
        logic [7:0]     sec_bcd;
        logic [7:0]     min_bcd;
        logic [7:0]     hour_bcd;
        logic           lamp;
        logic           boost;
        t_clock_reading due_readings[$];
        int             errors;
        int             checked;
        int             ticks;
        int             samples;
        int             dark_samples;
        int             hour_steps;

        function new();
            tick_limit   = RST_TICKS_PER_SECOND;
            dusk_hour    = RST_EVENING_HOUR;
            dawn_hour    = RST_MORNING_HOUR;
            busy_level   = RST_TRAFFIC_THRESHOLD;
            prescale     = '0;
            sec_bcd      = '0;
            min_bcd      = '0;
            hour_bcd     = '0;
            lamp         = 1'b1;
            boost        = 1'b1;
            errors       = 0;
            checked      = 0;
            ticks        = 0;
            samples      = 0;
            dark_samples = 0;
            hour_steps   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] data);
            case (idx)
                CFG_TICKS_PER_SECOND:  tick_limit = data[5:0];
                CFG_EVENING_HOUR:      dusk_hour  = data[5:0];
                CFG_MORNING_HOUR:      dawn_hour  = data[5:0];
                CFG_TRAFFIC_THRESHOLD: busy_level = data;
                default: ;
            endcase
        endfunction

        // Two-digit packed BCD count; the tens digit simply wraps in four bits.
        function logic [7:0] next_bcd(logic [7:0] v);
            if (v[3:0] >= 4'd9) begin
                return {v[7:4] + 4'd1, 4'd0};
            end
            return v + 8'd1;
        endfunction

        function void tick_second();
            sec_bcd = next_bcd(sec_bcd);
            if (sec_bcd < 8'h60) return;
            sec_bcd = '0;
            min_bcd = next_bcd(min_bcd);
            if (min_bcd < 8'h60) return;
            min_bcd  = '0;
            hour_bcd = next_bcd(hour_bcd);
            if (hour_bcd >= 8'h24) hour_bcd = '0;
            hour_steps++;
            // The window bounds are plain unsigned compares, valid BCD or not.
            lamp = (hour_bcd >= {2'b00, dusk_hour}) || (hour_bcd < {2'b00, dawn_hour});
        endfunction

        function void take_beat(logic act, logic [7:0] level);
            int limit;
            if (act == ACT_TICK) begin
                ticks++;
                limit = (tick_limit == 6'd0) ? 1 : int'(tick_limit);
                if (int'(prescale) + 1 >= limit) begin
                    prescale = '0;
                    tick_second();
                end else begin
                    prescale = prescale + 6'd1;
                end
            end else begin
                samples++;
                if (lamp) begin
                    boost = (level > busy_level);
                end else begin
                    dark_samples++;
                end
            end
            due_readings.push_back('{hours: hour_bcd[5:0], minutes: min_bcd[6:0],
                                     seconds: sec_bcd[6:0], lights: lamp, volts: boost});
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 25) begin
                $display("MISMATCH at %0t ns: %s", $time, what);
            end
        endtask

        task match_reading(t_clock_reading got);
            t_clock_reading want;
            if (due_readings.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing outstanding: %p", got));
                return;
            end
            want = due_readings.pop_front();
            checked++;
            if (got.hours !== want.hours)
                report_mismatch($sformatf("reading %0d hours %h, want %h",
                                          checked, got.hours, want.hours));
            if (got.minutes !== want.minutes)
                report_mismatch($sformatf("reading %0d minutes %h, want %h",
                                          checked, got.minutes, want.minutes));
            if (got.seconds !== want.seconds)
                report_mismatch($sformatf("reading %0d seconds %h, want %h",
                                          checked, got.seconds, want.seconds));
            if (got.lights !== want.lights)
                report_mismatch($sformatf("reading %0d lights_on %b, want %b",
                                          checked, got.lights, want.lights));
            if (got.volts !== want.volts)
                report_mismatch($sformatf("reading %0d high_voltage %b, want %b",
                                          checked, got.volts, want.volts));
        endtask

        function int pending();
            return due_readings.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    logic           action;
    logic [7:0]     sample;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic [5:0]     hours_bcd;
    logic [6:0]     minutes_bcd;
    logic [6:0]     seconds_bcd;
    logic           lights_on;
    logic           high_voltage;
    logic           cfg_we;
    t_cfg_idx       cfg_index;
    logic [7:0]     cfg_data;

    clock_light_tracker tracker;
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_left = 0;

    bcd_clock_street_light_control uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action),
        .i_sample       (sample),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_hours_bcd    (hours_bcd),
        .o_minutes_bcd  (minutes_bcd),
        .o_seconds_bcd  (seconds_bcd),
        .o_lights_on    (lights_on),
        .o_high_voltage (high_voltage),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // The receiver stalls on its own pattern: it picks a mode for a random stretch
    // of cycles, either never stalling, stalling now and then, or stalling most of
    // the time, so that back-pressure lands on every phase of the block's pipeline.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(16, 200);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: stall_mode = 0;
                    17, 18, 19:             stall_mode = 2;
                    default:                stall_mode = 1;
                endcase
            end
            stall_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Everything is observed at the rising edge, before the block's own registers
    // update: register writes and accepted input beats feed the tracker, and every
    // accepted output beat is checked against the oldest reading it owes.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) tracker.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall) tracker.take_beat(action, sample);
            if (out_valid && !out_stall)
                tracker.match_reading('{hours: hours_bcd, minutes: minutes_bcd,
                                        seconds: seconds_bcd, lights: lights_on,
                                        volts: high_voltage});
        end
    end

    // Offers one beat and returns at the falling edge after it was taken. The sender
    // works in bursts; a burst that ends drops valid before the next burst begins, and
    // valid is otherwise left high so back-to-back beats never toggle it.
    task automatic send_beat(input logic act, input logic [7:0] level);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= level;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        @(negedge clk);
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    // Closes a phase: stops offering beats and waits until every reading has arrived,
    // which leaves the block idle and ready for register writes.
    task automatic end_phase();
        if (burst_left != 0) begin
            in_valid   <= 1'b0;
            burst_left = 0;
        end
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Writes all four registers back to back; only called while idle.
    task automatic load_config(input logic [7:0] rate, input logic [7:0] dusk,
                               input logic [7:0] dawn, input logic [7:0] level);
        put_reg(CFG_TICKS_PER_SECOND, rate);
        put_reg(CFG_EVENING_HOUR, dusk);
        put_reg(CFG_MORNING_HOUR, dawn);
        put_reg(CFG_TRAFFIC_THRESHOLD, level);
        cfg_we <= 1'b0;
    endtask

    // Sensor readings: half uniform, half within two counts of the threshold so the
    // strictly-above compare is exercised on both sides of its boundary.
    function automatic logic [7:0] pick_sample(input logic [7:0] level);
        int v;
        if ($urandom_range(0, 1) == 1) return 8'($urandom);
        v = int'(level) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    initial begin
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_TICK;
        sample    = 8'd0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TICKS_PER_SECOND;
        cfg_data  = 8'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset configuration. Both latches come up high, so
        // samples steer the voltage latch; 15 equals the threshold and must clear it.
        send_beat(ACT_SAMPLE, 8'd255);
        send_beat(ACT_SAMPLE, 8'd0);
        send_beat(ACT_SAMPLE, 8'd15);
        send_beat(ACT_SAMPLE, 8'd16);
        repeat (3) send_beat(ACT_TICK, 8'd0);
        end_phase();

        // A zero rate behaves like one tick per second; nothing is above 255.
        load_config(8'h00, 8'h18, 8'h05, 8'hFF);
        repeat (3) send_beat(ACT_TICK, 8'hFF);
        send_beat(ACT_SAMPLE, 8'd255);
        send_beat(ACT_SAMPLE, 8'd0);
        end_phase();

        // Slowest rate, zero threshold: run the prescaler up, then lower the rate
        // below the count so the next tick must advance a second and clear it.
        load_config(8'h3F, 8'h00, 8'h00, 8'h00);
        repeat (10) send_beat(ACT_TICK, 8'h00);
        send_beat(ACT_SAMPLE, 8'd0);
        send_beat(ACT_SAMPLE, 8'd1);
        end_phase();
        load_config(8'h03, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_TICK, 8'h00);
        send_beat(ACT_SAMPLE, 8'd128);
        end_phase();

        // Random part: mixed ticks and samples over several register settings,
        // with the upper bits of the narrow registers driven as well.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       load_config(8'hC0, 8'($urandom), 8'($urandom), 8'h00);
                1:       load_config(8'h3F, 8'($urandom), 8'($urandom), 8'hFF);
                2:       load_config(8'h01, 8'($urandom), 8'($urandom), 8'($urandom));
                default: load_config({2'($urandom), 6'($urandom_range(0, 9))},
                                     8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            repeat (144) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(ACT_SAMPLE, pick_sample(tracker.busy_level));
                end else begin
                    send_beat(ACT_TICK, 8'($urandom));
                end
            end
            end_phase();
        end

        // Keep the clock running so a stray extra result would still be caught.
        repeat (10) @(posedge clk);
        $display("Covered %0d beats: %0d timer ticks and %0d sensor samples, %0d of them dark.",
                 tracker.ticks + tracker.samples, tracker.ticks, tracker.samples,
                 tracker.dark_samples);
        $display("Clock saw %0d hour changes; %0d readings compared.",
                 tracker.hour_steps, tracker.checked);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("bcd_clock_street_light_control regression: pass");
        end else begin
            $display("bcd_clock_street_light_control regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about twelve hundred beats.
    initial begin
        #2000000;
        $display("Timed out with %0d readings still outstanding.", tracker.pending());
        $display("bcd_clock_street_light_control regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bcslc_pkg.sv
hw/rtl/bcd_clock_street_light_control.sv
tb/tb_bcd_clock_street_light_control.sv
